### rtl/core/bor_pkg.sv
// Shared constants and types for the box overlap ratio block.
`default_nettype none

package bor_pkg;

    // Coordinate and fraction widths
    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 16;

    // Derived arithmetic widths
    localparam int AREA_BITS   = 2 * COORD_BITS;
    localparam int UNI_BITS    = AREA_BITS + 1;
    localparam int RATIO_BITS  = FRAC_BITS + 1;

    // Queue between the classify and compute sections
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [RATIO_BITS-1:0] ratio_t;

    // Classified box pair: flags plus the extents the area math needs
    typedef struct packed {
        logic   bad;
        logic   hit;
        coord_t a_w;
        coord_t a_h;
        coord_t b_w;
        coord_t b_h;
        coord_t i_w;
        coord_t i_h;
    } job_t;

endpackage

`default_nettype wire

### rtl/core/bor_pair_if.sv
// Valid/ready channel that carries one pair of boxes.
`default_nettype none

interface bor_pair_if;
    logic            valid;
    logic            ready;
    bor_pkg::coord_t first_left;
    bor_pkg::coord_t first_top;
    bor_pkg::coord_t first_right;
    bor_pkg::coord_t first_bottom;
    bor_pkg::coord_t second_left;
    bor_pkg::coord_t second_top;
    bor_pkg::coord_t second_right;
    bor_pkg::coord_t second_bottom;

    modport source (
        output valid, first_left, first_top, first_right, first_bottom,
               second_left, second_top, second_right, second_bottom,
        input  ready
    );

    modport sink (
        input  valid, first_left, first_top, first_right, first_bottom,
               second_left, second_top, second_right, second_bottom,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/bor_result_if.sv
// Valid/ready channel that carries one overlap ratio result.
`default_nettype none

interface bor_result_if;
    logic            valid;
    logic            ready;
    bor_pkg::ratio_t overlap_ratio;
    logic            status;

    modport source (
        output valid, overlap_ratio, status,
        input  ready
    );

    modport sink (
        input  valid, overlap_ratio, status,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/bor_front.sv
// Front section: accept a box pair, check extents and form the intersection.
`default_nettype none

module bor_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bor_pair_if.sink           pair,
    output bor_pkg::job_t      q_job,
    output logic               q_push,
    input  wire logic          q_full
);

    logic            valid_reg;
    bor_pkg::job_t   job_reg;
    bor_pkg::job_t   job_next;
    logic            accept;
    bor_pkg::coord_t il;
    bor_pkg::coord_t it;
    bor_pkg::coord_t ir;
    bor_pkg::coord_t ib;

    // Intersect the boxes and classify the pair
    always_comb
    begin
        il = (pair.first_left  > pair.second_left)   ? pair.first_left   : pair.second_left;
        it = (pair.first_top   > pair.second_top)    ? pair.first_top    : pair.second_top;
        ir = (pair.first_right < pair.second_right)  ? pair.first_right  : pair.second_right;
        ib = (pair.first_bottom < pair.second_bottom) ? pair.first_bottom : pair.second_bottom;

        job_next.bad = (pair.first_right   <= pair.first_left)  ||
                       (pair.first_bottom  <= pair.first_top)   ||
                       (pair.second_right  <= pair.second_left) ||
                       (pair.second_bottom <= pair.second_top);
        job_next.hit = (ir > il) && (ib > it);
        job_next.a_w = pair.first_right   - pair.first_left;
        job_next.a_h = pair.first_bottom  - pair.first_top;
        job_next.b_w = pair.second_right  - pair.second_left;
        job_next.b_h = pair.second_bottom - pair.second_top;
        job_next.i_w = ir - il;
        job_next.i_h = ib - it;
    end

    // Take a new item when none is held or the held one can move into the queue
    assign q_push     = valid_reg && !q_full;
    assign pair.ready = !valid_reg || !q_full;
    assign accept     = pair.valid && pair.ready;
    assign q_job      = job_reg;

    // Hold the classified item until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bor_queue.sv
// Short item queue that decouples the front and back sections.
`default_nettype none

module bor_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bor_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output bor_pkg::job_t      pop_job,
    output logic               nonempty
);

    localparam int CNT_BITS = bor_pkg::QPTR_BITS + 1;

    bor_pkg::job_t                    slot_reg [bor_pkg::QUEUE_DEPTH];
    logic [bor_pkg::QPTR_BITS-1:0]    wr_ptr_reg;
    logic [bor_pkg::QPTR_BITS-1:0]    rd_ptr_reg;
    logic [CNT_BITS-1:0]              count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full     = (count_reg == CNT_BITS'(bor_pkg::QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign pop_job  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == bor_pkg::QPTR_BITS'(bor_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == bor_pkg::QPTR_BITS'(bor_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bor_back.sv
// Back section: areas, union and a pipelined restoring fraction divider.
`default_nettype none

module bor_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bor_pkg::job_t q_job,
    input  wire logic          q_nonempty,
    output logic               q_pop,
    bor_result_if.source       result
);

    localparam int UB = bor_pkg::UNI_BITS;
    localparam int AB = bor_pkg::AREA_BITS;
    localparam int RB = bor_pkg::RATIO_BITS;
    localparam int NS = bor_pkg::FRAC_BITS;

    logic                  en;

    // Product stage
    logic                  m_valid_reg;
    logic                  m_bad_reg;
    logic                  m_hit_reg;
    logic [AB-1:0]         m_area_a_reg;
    logic [AB-1:0]         m_area_b_reg;
    logic [AB-1:0]         m_inter_reg;

    // Union stage
    logic                  u_valid_reg;
    logic                  u_bad_reg;
    logic                  u_hit_reg;
    logic [UB-1:0]         u_uni_reg;
    logic [UB-1:0]         u_inter_reg;
    logic [UB-1:0]         u_uni_next;

    // Divider stages: index 0 holds the integer part, index k after k steps
    logic                  d_valid_reg [NS+1];
    logic                  d_bad_reg   [NS+1];
    logic                  d_hit_reg   [NS+1];
    logic [UB-1:0]         d_rem_reg   [NS+1];
    logic [UB-1:0]         d_den_reg   [NS+1];
    logic [RB-1:0]         d_quo_reg   [NS+1];
    logic                  q0_next;

    // Output register
    logic                  out_valid_reg;
    logic [RB-1:0]         ratio_reg;
    logic                  status_reg;

    // Advance the whole pipe unless the output holds an untaken item
    assign en    = !out_valid_reg || result.ready;
    assign q_pop = en;

    assign result.valid         = out_valid_reg;
    assign result.overlap_ratio = ratio_reg;
    assign result.status        = status_reg;

    assign u_uni_next = UB'(m_area_a_reg) + UB'(m_area_b_reg) - UB'(m_inter_reg);
    assign q0_next    = (u_inter_reg >= u_uni_reg);

    // Valid bits of the fixed stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            u_valid_reg   <= 1'b0;
            d_valid_reg[0] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg    <= q_nonempty;
            u_valid_reg    <= m_valid_reg;
            d_valid_reg[0] <= u_valid_reg;
            out_valid_reg  <= d_valid_reg[NS];
        end
    end

    // Payload of the fixed stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_bad_reg    <= q_job.bad;
            m_hit_reg    <= q_job.hit;
            m_area_a_reg <= AB'(q_job.a_w) * AB'(q_job.a_h);
            m_area_b_reg <= AB'(q_job.b_w) * AB'(q_job.b_h);
            m_inter_reg  <= AB'(q_job.i_w) * AB'(q_job.i_h);

            u_bad_reg    <= m_bad_reg;
            u_hit_reg    <= m_hit_reg;
            u_uni_reg    <= u_uni_next;
            u_inter_reg  <= UB'(m_inter_reg);

            d_bad_reg[0] <= u_bad_reg;
            d_hit_reg[0] <= u_hit_reg;
            d_den_reg[0] <= u_uni_reg;
            d_quo_reg[0] <= RB'(q0_next);
            d_rem_reg[0] <= q0_next ? (u_inter_reg - u_uni_reg) : u_inter_reg;

            // Drop the ratio to zero for bad or disjoint pairs
            status_reg   <= d_bad_reg[NS];
            ratio_reg    <= (d_bad_reg[NS] || !d_hit_reg[NS]) ? '0 : d_quo_reg[NS];
        end
    end

    // One restoring step per stage: shift, compare, subtract
    genvar k;
    for (k = 1; k <= NS; k++)
    begin : g_step
        logic [UB:0]   shifted;
        logic          ge;
        logic [UB:0]   diff;

        assign shifted = {d_rem_reg[k-1], 1'b0};
        assign ge      = (shifted >= {1'b0, d_den_reg[k-1]});
        assign diff    = shifted - {1'b0, d_den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_bad_reg[k] <= d_bad_reg[k-1];
                d_hit_reg[k] <= d_hit_reg[k-1];
                d_den_reg[k] <= d_den_reg[k-1];
                d_rem_reg[k] <= ge ? diff[UB-1:0] : shifted[UB-1:0];
                d_quo_reg[k] <= {d_quo_reg[k-1][RB-2:0], ge};
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/box_overlap_ratio.sv
// An accepted pair passes the classify register, which loads at the accepting edge, then the
// queue, the area products, the union, the integer part, 16 divider steps and the output
// register; one quotient bit per stage. One pair per cycle while the queue has room; the
// four-entry queue lets the input side keep accepting pairs while the result side stalls,
// until the queue and the classify register are full.
// Reset: rst_n clears all valid bits and queue pointers; no result is pending.
`default_nettype none

module box_overlap_ratio (
    input  wire logic      clk,
    input  wire logic      rst_n,
    bor_pair_if.sink       pair,
    bor_result_if.source   result
);

    bor_pkg::job_t push_job;
    bor_pkg::job_t pop_job;
    logic          push;
    logic          full;
    logic          pop;
    logic          nonempty;

    bor_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair),
        .q_job  (push_job),
        .q_push (push),
        .q_full (full)
    );

    bor_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .nonempty (nonempty)
    );

    bor_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_job      (pop_job),
        .q_nonempty (nonempty),
        .q_pop      (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

### rtl/core/bor_checker.sv
// Port-level assertions for the box overlap ratio block, with its bind.
`default_nettype none

module bor_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                pair_valid,
    input wire logic                pair_ready,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire bor_pkg::ratio_t     overlap_ratio,
    input wire logic                status
);

    logic [7:0] inflight_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = pair_valid && pair_ready;
    assign out_acc = result_valid && result_ready;

    // Track items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            inflight_reg <= inflight_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_reg <= inflight_reg - 1'b1;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(overlap_ratio) && $stable(status))
        else $error("result changed while stalled");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> overlap_ratio == '0)
        else $error("invalid box pair with nonzero ratio");

    a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> overlap_ratio <= {1'b1, {bor_pkg::FRAC_BITS{1'b0}}})
        else $error("ratio above one");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> inflight_reg != '0)
        else $error("result delivered with no pair outstanding");

endmodule

bind box_overlap_ratio bor_checker u_bor_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .pair_valid    (pair.valid),
    .pair_ready    (pair.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .overlap_ratio (result.overlap_ratio),
    .status        (result.status)
);

`default_nettype wire

### tb/overlap_checker.sv
// Checker that predicts each overlap ratio result and compares it with the block.
`timescale 1ns / 100ps

module overlap_checker (
    input  logic   clk,
    input  logic   rst_n,
    bor_pair_if    pair,
    bor_result_if  result,
    output int     mismatches,
    output int     outstanding
);
    import bor_pkg::*;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_BOX = 1'b1;

    typedef struct packed {
        ratio_t ratio;
        logic   status;
    } overlap_t;

    overlap_t expected_q[$];
    overlap_t want;
    int       n_bad  = 0;
    int       n_wait = 0;

    assign mismatches  = n_bad;
    assign outstanding = n_wait;

    // Exact intersection over union with FRAC_BITS fraction bits
    function automatic overlap_t predict_overlap(
        coord_t al, coord_t at, coord_t ar, coord_t ab,
        coord_t bl, coord_t bt, coord_t br, coord_t bb
    );
        overlap_t   o;
        bit [63:0]  il;
        bit [63:0]  it;
        bit [63:0]  ir;
        bit [63:0]  ib;
        bit [63:0]  inter;
        bit [63:0]  uni;
        o.ratio  = '0;
        o.status = STATUS_OK;
        if (ar <= al || ab <= at || br <= bl || bb <= bt)
        begin
            o.status = STATUS_BAD_BOX;
        end
        else
        begin
            il = (al > bl) ? al : bl;
            it = (at > bt) ? at : bt;
            ir = (ar < br) ? ar : br;
            ib = (ab < bb) ? ab : bb;
            // no overlap, or edges only touching, leaves the ratio at zero
            if (ir > il && ib > it)
            begin
                inter = (ir - il) * (ib - it);
                uni   = 64'(ar - al) * 64'(ab - at) + 64'(br - bl) * 64'(bb - bt) - inter;
                o.ratio = ratio_t'((inter << FRAC_BITS) / uni);
            end
        end
        return o;
    endfunction

    // Queue an expectation per accepted pair, check each accepted result
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            n_wait = 0;
        end
        else
        begin
            if (pair.valid && pair.ready)
            begin
                expected_q.push_back(predict_overlap(
                    pair.first_left, pair.first_top, pair.first_right, pair.first_bottom,
                    pair.second_left, pair.second_top, pair.second_right,
                    pair.second_bottom));
            end
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    n_bad++;
                    $display("%0t: result with none pending: ratio %0d status %0d",
                             $time, result.overlap_ratio, result.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.overlap_ratio !== want.ratio)
                    begin
                        n_bad++;
                        $display("%0t: overlap_ratio expected %0d got %0d",
                                 $time, want.ratio, result.overlap_ratio);
                    end
                    if (result.status !== want.status)
                    begin
                        n_bad++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, result.status);
                    end
                end
            end
            n_wait = expected_q.size();
        end
    end

endmodule

### tb/tb_box_overlap_ratio.sv
// Testbench top: box pair stimulus, result-side stalls and the final verdict.
`timescale 1ns / 100ps

module tb_box_overlap_ratio;
    import bor_pkg::*;

    localparam int RANDOM_PAIRS = 530;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 150;
    localparam int BURST_FROM   = 100;
    localparam int BURST_TO     = 260;
    localparam int PAUSE_AT     = 350;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

    typedef struct packed {
        coord_t first_left;
        coord_t first_top;
        coord_t first_right;
        coord_t first_bottom;
        coord_t second_left;
        coord_t second_top;
        coord_t second_right;
        coord_t second_bottom;
    } box_pair_t;

    logic clk;
    logic rst_n;
    int   accepted_pairs = 0;
    int   mismatches;
    int   outstanding;
    bit   long_hold_done = 1'b0;

    bor_pair_if   pair ();
    bor_result_if result ();

    box_overlap_ratio uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair),
        .result (result)
    );

    overlap_checker ratio_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pair        (pair),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic box_pair_t pair_of(
        int fl, int ft, int fr, int fb, int sl, int st, int sr, int sb
    );
        box_pair_t p;
        p = {coord_t'(fl), coord_t'(ft), coord_t'(fr), coord_t'(fb),
             coord_t'(sl), coord_t'(st), coord_t'(sr), coord_t'(sb)};
        return p;
    endfunction

    // Random edge pair with lo < hi; narrow, medium or wide extents
    function automatic void rand_span(output coord_t lo, output coord_t hi);
        int a;
        int b;
        a = int'($urandom_range(0, COORD_MAX - 1));
        case ($urandom_range(0, 3))
            0:       b = a + 1 + int'($urandom_range(0, 15));
            1:       b = a + 1 + int'($urandom_range(0, 1023));
            default: b = int'($urandom_range(a + 1, COORD_MAX));
        endcase
        if (b > COORD_MAX)
            b = COORD_MAX;
        lo = coord_t'(a);
        hi = coord_t'(b);
    endfunction

    // Edge pair near a given span, so the boxes mostly overlap
    function automatic void near_span(input coord_t lo, input coord_t hi,
                                      output coord_t nlo, output coord_t nhi);
        int w;
        int d;
        int l;
        int w2;
        int h;
        w  = int'(hi) - int'(lo);
        d  = int'($urandom_range(0, 2 * w + 2)) - (w + 1);
        l  = int'(lo) + d;
        if (l < 0)
            l = 0;
        if (l > COORD_MAX - 1)
            l = COORD_MAX - 1;
        w2 = w + int'($urandom_range(0, w)) - w / 2;
        if (w2 < 1)
            w2 = 1;
        h  = l + w2;
        if (h > COORD_MAX)
            h = COORD_MAX;
        nlo = coord_t'(l);
        nhi = coord_t'(h);
    endfunction

    // Mostly overlapping pairs, some independent, identical, degenerate and raw noise
    function automatic box_pair_t make_random_pair();
        box_pair_t   p;
        int unsigned kind;
        coord_t      tmp;
        kind = $urandom_range(0, 99);
        rand_span(p.first_left, p.first_right);
        rand_span(p.first_top, p.first_bottom);
        if (kind < 70 && kind >= 55)
        begin
            rand_span(p.second_left, p.second_right);
            rand_span(p.second_top, p.second_bottom);
        end
        else if (kind < 78 && kind >= 70)
        begin
            p.second_left   = p.first_left;
            p.second_top    = p.first_top;
            p.second_right  = p.first_right;
            p.second_bottom = p.first_bottom;
        end
        else
        begin
            near_span(p.first_left, p.first_right, p.second_left, p.second_right);
            near_span(p.first_top, p.first_bottom, p.second_top, p.second_bottom);
        end
        // break one box: zero extent or reversed edges
        if (kind >= 78 && kind < 88)
        begin
            case ($urandom_range(0, 7))
                0: p.first_right = p.first_left;
                1: begin tmp = p.first_left; p.first_left = p.first_right;
                         p.first_right = tmp; end
                2: p.first_bottom = p.first_top;
                3: begin tmp = p.first_top; p.first_top = p.first_bottom;
                         p.first_bottom = tmp; end
                4: p.second_right = p.second_left;
                5: begin tmp = p.second_left; p.second_left = p.second_right;
                         p.second_right = tmp; end
                6: p.second_bottom = p.second_top;
                default: begin tmp = p.second_top; p.second_top = p.second_bottom;
                               p.second_bottom = tmp; end
            endcase
        end
        else if (kind >= 88)
        begin
            p = {$urandom(), $urandom(), $urandom(), $urandom()};
        end
        return p;
    endfunction

    // Sender gap: none during the burst window, else mostly short and a few long
    function automatic int next_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (accepted_pairs >= BURST_FROM && accepted_pairs < BURST_TO)
            return 0;
        if (pick < 60)
            return 0;
        if (pick < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // Offer one item after an optional gap and hold it until accepted
    task automatic offer_pair(input box_pair_t p, input int gap);
        if (gap > 0)
        begin
            pair.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair.valid <= 1'b1;
        {pair.first_left, pair.first_top, pair.first_right, pair.first_bottom,
         pair.second_left, pair.second_top, pair.second_right, pair.second_bottom} <= p;
        @(posedge clk);
        while (!pair.ready)
            @(posedge clk);
        accepted_pairs++;
    endtask

    // Stimulus and verdict
    initial
    begin
        int i;
        rst_n      <= 1'b0;
        pair.valid <= 1'b0;
        {pair.first_left, pair.first_top, pair.first_right, pair.first_bottom,
         pair.second_left, pair.second_top, pair.second_right, pair.second_bottom} <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identical boxes, mid range and full range
        offer_pair(pair_of(10, 20, 110, 220, 10, 20, 110, 220), next_gap());
        offer_pair(pair_of(0, 0, 65535, 65535, 0, 0, 65535, 65535), next_gap());
        // full frame against a single pixel
        offer_pair(pair_of(0, 0, 65535, 65535, 100, 100, 101, 101), next_gap());
        // degenerate first box: zero width, zero height, reversed edges
        offer_pair(pair_of(5, 5, 5, 10, 0, 0, 20, 20), next_gap());
        offer_pair(pair_of(5, 7, 10, 7, 0, 0, 20, 20), next_gap());
        offer_pair(pair_of(65535, 65535, 0, 0, 0, 0, 20, 20), next_gap());
        // degenerate second box
        offer_pair(pair_of(0, 0, 20, 20, 9, 3, 9, 8), next_gap());
        offer_pair(pair_of(0, 0, 20, 20, 3, 9, 8, 2), next_gap());
        offer_pair(pair_of(0, 0, 20, 20, 8, 2, 3, 9), next_gap());
        // all zero and all ones coordinates
        offer_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0), next_gap());
        offer_pair(pair_of(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535),
                   next_gap());
        // disjoint and touching boxes
        offer_pair(pair_of(0, 0, 10, 10, 20, 0, 30, 10), next_gap());
        offer_pair(pair_of(0, 0, 10, 10, 10, 0, 20, 10), next_gap());
        offer_pair(pair_of(0, 0, 10, 10, 0, 10, 10, 20), next_gap());
        offer_pair(pair_of(0, 40, 10, 50, 0, 0, 10, 10), next_gap());
        offer_pair(pair_of(20, 20, 30, 30, 0, 0, 20, 20), next_gap());
        // nested both ways, partial and half overlaps
        offer_pair(pair_of(0, 0, 100, 100, 25, 25, 75, 75), next_gap());
        offer_pair(pair_of(25, 25, 75, 75, 0, 0, 100, 100), next_gap());
        offer_pair(pair_of(0, 0, 10, 10, 5, 5, 15, 15), next_gap());
        offer_pair(pair_of(0, 0, 100, 50, 50, 0, 150, 50), next_gap());
        // small and thin boxes at the top of the coordinate range
        offer_pair(pair_of(65530, 65530, 65535, 65535, 65534, 65534, 65535, 65535),
                   next_gap());
        offer_pair(pair_of(0, 65534, 65535, 65535, 65534, 0, 65535, 65535), next_gap());

        for (i = 0; i < RANDOM_PAIRS; i++)
        begin
            // let every pending result drain once before going on
            if (accepted_pairs == PAUSE_AT)
            begin
                pair.valid <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
                @(posedge clk);
            end
            offer_pair(make_random_pair(), next_gap());
        end
        pair.valid <= 1'b0;

        // let the checker count the last accepted pair before waiting on outstanding
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random ready stretches, one long hold-off to fill the block
    initial
    begin
        int unsigned pick;
        int unsigned len;
        result.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && accepted_pairs >= HOLD_AT)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    result.ready <= 1'b1;
                    len = $urandom_range(1, 20);
                end
                else if (pick < 95)
                begin
                    result.ready <= 1'b0;
                    len = $urandom_range(1, 4);
                end
                else
                begin
                    result.ready <= 1'b0;
                    len = $urandom_range(20, 60);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run after too many cycles with no item accepted
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((pair.valid && pair.ready) || (result.valid && result.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

### sim.f
rtl/core/bor_pkg.sv
rtl/core/bor_pair_if.sv
rtl/core/bor_result_if.sv
rtl/core/bor_front.sv
rtl/core/bor_queue.sv
rtl/core/bor_back.sv
rtl/core/box_overlap_ratio.sv
rtl/core/bor_checker.sv
tb/overlap_checker.sv
tb/tb_box_overlap_ratio.sv
